FILE: design/tru_pkg.sv
// ----------------------------------------------------------------------------
// tru_pkg
// Shared types and constants of the tiled result unpack block: register
// indexes, fixed register widths, controller states, command and status.
// ----------------------------------------------------------------------------
package tru_pkg;

    // configuration port
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_ROWS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_COLS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_ROWS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COLS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MICRO_ROWS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MICRO_COLS  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CORES       = 3'd6;

    // register widths and limits
    localparam int BLOCK_W   = 13;
    localparam int SMALL_W   = 7;
    localparam int BLOCK_MAX = 4096;
    localparam int CORES_MAX = 64;
    // cores * block_rows fits here
    localparam int GSPAN_W   = 19;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SPAN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_PROD,
        ST_MUL_HEIGHT,
        ST_MUL_WIDTH,
        ST_INIT,
        ST_STREAM
    } tru_state_t;

    // which setup division runs on the shared divider
    typedef enum logic [2:0] {
        DIV_GROUP,
        DIV_MR,
        DIV_CORE,
        DIV_BLK,
        DIV_NC,
        DIV_NR
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     span;
        logic     div_start;
        div_sel_t div_sel;
        logic     capture;
        logic     mul_prod;
        logic     mul_height;
        logic     mul_width;
        logic     init;
        logic     stream;
    } tru_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_item;
        logic cfg_write;
    } tru_status_t;

endpackage

FILE: design/tru_div.sv
// ----------------------------------------------------------------------------
// tru_div
// Restoring divider, one quotient bit per cycle. Gives quotient and
// remainder together with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module tru_div #(
    parameter int NW = 17,
    parameter int DW = 19
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] n_reg, n_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [DW:0]   trial;
    logic          ge;

    // one restoring step
    always_comb
    begin
        trial     = {r_reg, n_reg[NW-1]};
        ge        = (trial >= {1'b0, d_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            n_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? DW'(trial - {1'b0, d_reg}) : trial[DW-1:0];
            n_next   = {n_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = n_reg;
    assign remainder = r_reg;

endmodule

FILE: design/tru_ctrl.sv
// ----------------------------------------------------------------------------
// tru_ctrl
// Sequencer: runs the setup steps (load, span, six divisions, products),
// then initializes the traversal and lets words stream, again after each matrix.
// ----------------------------------------------------------------------------
module tru_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tru_pkg::tru_status_t status,
    output tru_pkg::tru_cmd_t    cmd
);

    import tru_pkg::*;

    tru_state_t state_reg, state_next;
    div_sel_t   sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            sel_reg   <= DIV_GROUP;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                cmd.span   = 1'b1;
                sel_next   = DIV_GROUP;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.capture = 1'b1;
                    case (sel_reg)
                        DIV_GROUP:
                        begin
                            sel_next   = DIV_MR;
                            state_next = ST_DIV_GO;
                        end
                        DIV_MR:
                        begin
                            sel_next   = DIV_CORE;
                            state_next = ST_DIV_GO;
                        end
                        DIV_CORE:
                        begin
                            sel_next   = DIV_BLK;
                            state_next = ST_DIV_GO;
                        end
                        DIV_BLK:   state_next = ST_MUL_PROD;
                        DIV_NC:
                        begin
                            sel_next   = DIV_NR;
                            state_next = ST_DIV_GO;
                        end
                        DIV_NR:    state_next = ST_MUL_WIDTH;
                        default:   state_next = ST_LOAD;
                    endcase
                end
            end
            ST_MUL_PROD:
            begin
                cmd.mul_prod = 1'b1;
                state_next   = ST_MUL_HEIGHT;
            end
            ST_MUL_HEIGHT:
            begin
                cmd.mul_height = 1'b1;
                sel_next       = DIV_NC;
                state_next     = ST_DIV_GO;
            end
            ST_MUL_WIDTH:
            begin
                cmd.mul_width = 1'b1;
                state_next    = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_STREAM;
            end
            ST_STREAM:
            begin
                cmd.stream = 1'b1;
                if (status.last_item)
                begin
                    state_next = ST_INIT;
                end
            end
            default:   state_next = ST_LOAD;
        endcase
        // a register write restarts setup
        if (status.cfg_write)
        begin
            state_next = ST_LOAD;
        end
    end

endmodule

FILE: design/tru_datapath.sv
// ----------------------------------------------------------------------------
// tru_datapath
// Configuration registers, setup arithmetic around the shared divider,
// traversal counters and the output register.
// ----------------------------------------------------------------------------
module tru_datapath #(
    parameter int DIM_WIDTH   = 16,
    parameter int MICRO_WIDTH = 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [tru_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [tru_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [31:0]                           packed_word,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [31:0]                           write_address,
    output logic [31:0]                           write_data,
    output logic                                  write_enable,
    output logic                                  block_last,
    output logic                                  matrix_last,
    input  tru_pkg::tru_cmd_t                     cmd,
    output tru_pkg::tru_status_t                  status
);

    import tru_pkg::*;

    localparam int DIM = DIM_WIDTH;
    localparam int MW  = MICRO_WIDTH;
    localparam int MU  = MICRO_WIDTH + 1;
    localparam int NW  = DIM + 1;
    localparam int DW  = (DIM > GSPAN_W) ? DIM : GSPAN_W;
    localparam int HW  = (DIM + 1 > BLOCK_W) ? DIM + 1 : BLOCK_W;
    localparam int PW  = DIM + 20;
    localparam int AW  = (2 * DIM + 2 > 32) ? 2 * DIM + 2 : 32;
    localparam int XW  = DIM + SMALL_W;

    // configuration registers
    logic [15:0]        rows_cfg_reg, cols_cfg_reg;
    logic [BLOCK_W-1:0] mc_cfg_reg, nc_cfg_reg;
    logic [SMALL_W-1:0] mr_cfg_reg, nr_cfg_reg, p_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= 16'd1;
            cols_cfg_reg <= 16'd1;
            mc_cfg_reg   <= BLOCK_W'(1);
            nc_cfg_reg   <= BLOCK_W'(1);
            mr_cfg_reg   <= SMALL_W'(1);
            nr_cfg_reg   <= SMALL_W'(1);
            p_cfg_reg    <= SMALL_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MATRIX_ROWS: rows_cfg_reg <= cfg_data;
                REG_MATRIX_COLS: cols_cfg_reg <= cfg_data;
                REG_BLOCK_ROWS:  mc_cfg_reg   <= cfg_data[BLOCK_W-1:0];
                REG_BLOCK_COLS:  nc_cfg_reg   <= cfg_data[BLOCK_W-1:0];
                REG_MICRO_ROWS:  mr_cfg_reg   <= cfg_data[SMALL_W-1:0];
                REG_MICRO_COLS:  nr_cfg_reg   <= cfg_data[SMALL_W-1:0];
                REG_CORES:       p_cfg_reg    <= cfg_data[SMALL_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamp register values into their working ranges
    logic [31:0] dmask, umax;
    logic [31:0] m32, n32, mc32, nc32, mr32, nr32, p32;

    function automatic logic [31:0] clamp32(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        r = v;
        if (v == 32'd0)
        begin
            r = 32'd1;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    always_comb
    begin
        dmask = (32'd1 << DIM) - 32'd1;
        umax  = 32'd1 << MW;
        m32   = clamp32({16'b0, rows_cfg_reg} & dmask, dmask);
        n32   = clamp32({16'b0, cols_cfg_reg} & dmask, dmask);
        mc32  = clamp32(32'(mc_cfg_reg), 32'(BLOCK_MAX));
        nc32  = clamp32(32'(nc_cfg_reg), 32'(BLOCK_MAX));
        mr32  = clamp32(32'(mr_cfg_reg), umax);
        nr32  = clamp32(32'(nr_cfg_reg), umax);
        p32   = clamp32(32'(p_cfg_reg), 32'(CORES_MAX));
    end

    // setup registers
    logic [DIM-1:0]     e_m_reg, e_n_reg;
    logic [BLOCK_W-1:0] e_mc_reg, e_nc_reg;
    logic [MU-1:0]      e_mr_reg, e_nr_reg;
    logic [SMALL_W-1:0] e_p_reg;
    logic [GSPAN_W-1:0] gs_reg;
    logic [DIM-1:0]     rem_reg, fre_reg, mr_rem_reg, pc_reg, ncrem_reg, fce_reg;
    logic [SMALL_W-1:0] rb_reg;
    logic [NW-1:0]      qnr_reg;
    logic [XW-1:0]      prod_reg;
    logic [HW-1:0]      rh_reg, lch_reg, rw_reg;

    // shared divider
    logic [NW-1:0] dvd;
    logic [DW-1:0] dvs;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic [DW-1:0] div_rem;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_GROUP:
            begin
                dvd = {1'b0, e_m_reg};
                dvs = DW'(gs_reg);
            end
            DIV_MR:
            begin
                dvd = {1'b0, rem_reg} + NW'(e_mr_reg) - NW'(1);
                dvs = DW'(e_mr_reg);
            end
            DIV_CORE:
            begin
                dvd = {1'b0, mr_rem_reg} + NW'(e_p_reg) - NW'(1);
                dvs = DW'(e_p_reg);
            end
            DIV_BLK:
            begin
                dvd = {1'b0, mr_rem_reg} + {1'b0, pc_reg} - NW'(1);
                dvs = DW'(pc_reg);
            end
            DIV_NC:
            begin
                dvd = {1'b0, e_n_reg};
                dvs = DW'(e_nc_reg);
            end
            DIV_NR:
            begin
                dvd = {1'b0, ncrem_reg} + NW'(e_nr_reg) - NW'(1);
                dvs = DW'(e_nr_reg);
            end
            default:
            begin
                dvd = {1'b0, e_m_reg};
                dvs = DW'(gs_reg);
            end
        endcase
    end

    tru_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // setup products
    logic [DIM+MU-1:0] rh_full, lch_full;
    logic [NW+MU-1:0]  rw_full;
    logic [XW-1:0]     dfull;

    always_comb
    begin
        rh_full  = {{MU{1'b0}}, pc_reg} * {{DIM{1'b0}}, e_mr_reg};
        // last core height: per_core minus the overshoot of the rounded split
        dfull    = XW'(pc_reg) + XW'(mr_rem_reg) - prod_reg;
        lch_full = {{MU{1'b0}}, dfull[DIM-1:0]} * {{DIM{1'b0}}, e_mr_reg};
        rw_full  = {{MU{1'b0}}, qnr_reg} * {{NW{1'b0}}, e_nr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_m_reg  <= m32[DIM-1:0];
            e_n_reg  <= n32[DIM-1:0];
            e_mc_reg <= mc32[BLOCK_W-1:0];
            e_nc_reg <= nc32[BLOCK_W-1:0];
            e_mr_reg <= mr32[MU-1:0];
            e_nr_reg <= nr32[MU-1:0];
            e_p_reg  <= p32[SMALL_W-1:0];
        end
        if (cmd.span)
        begin
            gs_reg <= {{(GSPAN_W-SMALL_W){1'b0}}, e_p_reg}
                    * {{(GSPAN_W-BLOCK_W){1'b0}}, e_mc_reg};
        end
        if (cmd.capture)
        begin
            case (cmd.div_sel)
                DIV_GROUP:
                begin
                    rem_reg <= div_rem[DIM-1:0];
                    fre_reg <= e_m_reg - div_rem[DIM-1:0];
                end
                DIV_MR:    mr_rem_reg <= div_quo[DIM-1:0];
                DIV_CORE:  pc_reg <= div_quo[DIM-1:0];
                DIV_BLK:   rb_reg <= (pc_reg == '0) ? '0 : div_quo[SMALL_W-1:0];
                DIV_NC:
                begin
                    ncrem_reg <= div_rem[DIM-1:0];
                    fce_reg   <= e_n_reg - div_rem[DIM-1:0];
                end
                DIV_NR:    qnr_reg <= div_quo;
                default:   ;
            endcase
        end
        if (cmd.mul_prod)
        begin
            prod_reg <= {{DIM{1'b0}}, rb_reg} * {{SMALL_W{1'b0}}, pc_reg};
        end
        if (cmd.mul_height)
        begin
            rh_reg  <= HW'(rh_full);
            lch_reg <= HW'(lch_full);
        end
        if (cmd.mul_width)
        begin
            rw_reg <= HW'(rw_full);
        end
    end

    // traversal state
    logic [PW-1:0]      co_reg, co_next, go_reg, go_next, bo_reg, bo_next;
    logic [HW-1:0]      ch_reg, ch_next, cw_reg, cw_next;
    logic [HW-1:0]      pr_reg, pr_next, pcol_reg, pcol_next;
    logic [MW-1:0]      mrow_reg, mrow_next, mcol_reg, mcol_next;
    logic [SMALL_W-1:0] ri_reg, ri_next;

    logic          accept;
    logic [PW-1:0] row, col;
    logic          enable;
    logic [MU-1:0] mcol_inc, mrow_inc;
    logic [HW:0]   pr_inc, pcol_inc;
    logic          wrap_c, wrap_r, wrap_pr, wrap_pc, blast, finish, mlast;
    logic [PW-1:0] bo_step, go_step, co_step;
    logic [SMALL_W-1:0] ri_step;
    logic [HW-1:0] rem_first_h;
    logic [2*DIM-1:0] addr_prod;
    logic [AW-1:0]    addr_full;

    assign accept = in_valid && in_ready;

    // position, bounds and address
    always_comb
    begin
        row       = go_reg + bo_reg + PW'(pr_reg) + PW'(mrow_reg);
        col       = co_reg + PW'(pcol_reg) + PW'(mcol_reg);
        enable    = (row < PW'(e_m_reg)) && (col < PW'(e_n_reg));
        addr_prod = {{DIM{1'b0}}, row[DIM-1:0]} * {{DIM{1'b0}}, e_n_reg};
        addr_full = AW'(addr_prod) + AW'(col);
    end

    // micro-panel counters
    always_comb
    begin
        mcol_inc = {1'b0, mcol_reg} + MU'(1);
        mrow_inc = {1'b0, mrow_reg} + MU'(1);
        pr_inc   = {1'b0, pr_reg} + (HW+1)'(e_mr_reg);
        pcol_inc = {1'b0, pcol_reg} + (HW+1)'(e_nr_reg);
        wrap_c   = (mcol_inc >= e_nr_reg);
        wrap_r   = (mrow_inc >= e_mr_reg);
        wrap_pr  = (pr_inc >= {1'b0, ch_reg});
        wrap_pc  = (pcol_inc >= {1'b0, cw_reg});
        blast    = wrap_c && wrap_r && wrap_pr && wrap_pc;
    end

    // next block and next column; also the start of a matrix
    always_comb
    begin
        bo_step     = bo_reg + PW'(e_mc_reg);
        go_step     = go_reg + PW'(gs_reg);
        co_step     = co_reg + PW'(e_nc_reg);
        ri_step     = ri_reg + SMALL_W'(1);
        rem_first_h = (rb_reg == SMALL_W'(1)) ? lch_reg : rh_reg;
        co_next     = co_reg;
        go_next     = go_reg;
        bo_next     = bo_reg;
        ri_next     = ri_reg;
        ch_next     = ch_reg;
        cw_next     = cw_reg;
        pr_next     = pr_reg;
        pcol_next   = pcol_reg;
        mrow_next   = mrow_reg;
        mcol_next   = mcol_reg;
        finish      = 1'b0;
        if (cmd.init)
        begin
            co_next   = '0;
            cw_next   = (fce_reg != '0) ? HW'(e_nc_reg) : rw_reg;
            bo_next   = '0;
            ri_next   = '0;
            pr_next   = '0;
            pcol_next = '0;
            mrow_next = '0;
            mcol_next = '0;
            if (fre_reg != '0)
            begin
                go_next = '0;
                ch_next = HW'(e_mc_reg);
            end
            else
            begin
                go_next = PW'(fre_reg);
                ch_next = rem_first_h;
            end
        end
        else if (accept)
        begin
            // walk inside the block
            mcol_next = wrap_c ? '0 : mcol_inc[MW-1:0];
            if (wrap_c)
            begin
                mrow_next = wrap_r ? '0 : mrow_inc[MW-1:0];
                if (wrap_r)
                begin
                    pr_next = wrap_pr ? '0 : pr_inc[HW-1:0];
                    if (wrap_pr)
                    begin
                        pcol_next = wrap_pc ? '0 : pcol_inc[HW-1:0];
                    end
                end
            end
            // move to the next block
            if (blast)
            begin
                finish = 1'b0;
                if (go_reg < PW'(fre_reg))
                begin
                    if (bo_step < PW'(gs_reg))
                    begin
                        bo_next = bo_step;
                        ch_next = HW'(e_mc_reg);
                    end
                    else if (go_step < PW'(fre_reg))
                    begin
                        go_next = go_step;
                        bo_next = '0;
                        ch_next = HW'(e_mc_reg);
                    end
                    else if (rb_reg != '0)
                    begin
                        go_next = PW'(fre_reg);
                        bo_next = '0;
                        ri_next = '0;
                        ch_next = rem_first_h;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else if (ri_step < rb_reg)
                begin
                    ri_next = ri_step;
                    bo_next = bo_reg + PW'(rh_reg);
                    ch_next = (ri_step == rb_reg - SMALL_W'(1)) ? lch_reg : rh_reg;
                end
                else
                begin
                    finish = 1'b1;
                end
                // column advance once the rows of this column are used up
                if (finish)
                begin
                    if (co_reg < PW'(fce_reg))
                    begin
                        if ((co_step < PW'(fce_reg)) || (rw_reg != '0))
                        begin
                            finish  = 1'b0;
                            co_next = co_step;
                            cw_next = (co_step < PW'(fce_reg)) ? HW'(e_nc_reg) : rw_reg;
                            bo_next = '0;
                            ri_next = '0;
                            if (fre_reg != '0)
                            begin
                                go_next = '0;
                                ch_next = HW'(e_mc_reg);
                            end
                            else
                            begin
                                go_next = PW'(fre_reg);
                                ch_next = rem_first_h;
                            end
                        end
                    end
                end
            end
        end
        mlast = blast && finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            co_reg   <= '0;
            go_reg   <= '0;
            bo_reg   <= '0;
            ri_reg   <= '0;
            ch_reg   <= '0;
            cw_reg   <= '0;
            pr_reg   <= '0;
            pcol_reg <= '0;
            mrow_reg <= '0;
            mcol_reg <= '0;
        end
        else
        begin
            co_reg   <= co_next;
            go_reg   <= go_next;
            bo_reg   <= bo_next;
            ri_reg   <= ri_next;
            ch_reg   <= ch_next;
            cw_reg   <= cw_next;
            pr_reg   <= pr_next;
            pcol_reg <= pcol_next;
            mrow_reg <= mrow_next;
            mcol_reg <= mcol_next;
        end
    end

    // output register
    logic        out_valid_reg;
    logic [31:0] addr_reg, data_reg;
    logic        we_reg, blast_reg, mlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg  <= enable ? addr_full[31:0] : 32'd0;
            data_reg  <= packed_word;
            we_reg    <= enable;
            blast_reg <= blast;
            mlast_reg <= mlast;
        end
    end

    assign in_ready      = cmd.stream && (!out_valid_reg || out_ready);
    assign out_valid     = out_valid_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign write_enable  = we_reg;
    assign block_last    = blast_reg;
    assign matrix_last   = mlast_reg;

    assign status.div_done  = div_done;
    assign status.last_item = accept && mlast;
    // only a write to an existing register restarts setup
    assign status.cfg_write = cfg_we && (cfg_index <= REG_CORES);

endmodule

FILE: design/tiled_result_unpack_with_remainders.sv
// ----------------------------------------------------------------------------
// tiled_result_unpack_with_remainders
// Gives each packed output word of a blocked matrix multiply its row-major
// write address, with remainder rows and columns and padding flags.
// ----------------------------------------------------------------------------
// An accepted word's result is registered in the output register in the cycle after it is taken.
// Throughput: one word per cycle while streaming and the output is not held by out_ready low;
// no word is taken while the traversal restarts after the last word of a matrix.
// Setup after reset or a write to an existing register runs six divisions on the
// bit-serial divider, during which no word is accepted.
// Reset: registers read 1, output empty, setup starts right away.
module tiled_result_unpack_with_remainders #(
    parameter int DIM_WIDTH   = 16,
    parameter int MICRO_WIDTH = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tru_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tru_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [31:0]                     packed_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [31:0]                     write_address,
    output logic [31:0]                     write_data,
    output logic                            write_enable,
    output logic                            block_last,
    output logic                            matrix_last
);

    import tru_pkg::*;

    tru_cmd_t    cmd;
    tru_status_t status;

    tru_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    tru_datapath #(
        .DIM_WIDTH   (DIM_WIDTH),
        .MICRO_WIDTH (MICRO_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .packed_word   (packed_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_address (write_address),
        .write_data    (write_data),
        .write_enable  (write_enable),
        .block_last    (block_last),
        .matrix_last   (matrix_last),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
